>>> src/pose_error_speed_scale_defines.svh
// Assertion macros for the pose error block.
`ifndef POSE_ERROR_SPEED_SCALE_DEFINES_SVH
`define POSE_ERROR_SPEED_SCALE_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define PESC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("pose error block: assertion failed");

// Check that a condition never holds.
`define PESC_ASSERT_NEVER(lbl, cond) \
  `PESC_ASSERT(lbl, !(cond))

`endif

>>> src/pesc_pkg.sv
// Shared types and constants for the pose error and speed scale block.
`default_nettype none
package pesc_pkg;

  localparam int unsigned POSE_W      = 20;
  localparam int unsigned ERRY_W      = POSE_W + 2;
  localparam int unsigned REG_W       = 19;
  localparam int unsigned SCALE_W     = 18;
  localparam int unsigned SCALE_FRAC  = 16;
  localparam int unsigned NUM_LANES   = 3;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned CFG_IDX_W   = 3;

  localparam logic [SCALE_W-1:0] SCALE_MAX = {SCALE_W{1'b1}};

  localparam logic [REG_W-1:0] RST_YAW_HALF   = REG_W'(804);
  localparam logic [REG_W-1:0] RST_LIMIT_X    = REG_W'(5120);
  localparam logic [REG_W-1:0] RST_LIMIT_Y    = REG_W'(5120);
  localparam logic [REG_W-1:0] RST_MARGIN_YAW = REG_W'(13);
  localparam logic [REG_W-1:0] RST_MARGIN_X   = REG_W'(512);
  localparam logic [REG_W-1:0] RST_MARGIN_Y   = REG_W'(512);

  // Lane order in the divider
  localparam int unsigned LANE_YAW = 0;
  localparam int unsigned LANE_X   = 1;
  localparam int unsigned LANE_Y   = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_YAW_HALF   = 3'd0,
    CFG_LIMIT_X    = 3'd1,
    CFG_LIMIT_Y    = 3'd2,
    CFG_MARGIN_YAW = 3'd3,
    CFG_MARGIN_X   = 3'd4,
    CFG_MARGIN_Y   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [REG_W-1:0] yaw_half;
    logic [REG_W-1:0] limit_x;
    logic [REG_W-1:0] limit_y;
    logic [REG_W-1:0] margin_yaw;
    logic [REG_W-1:0] margin_x;
    logic [REG_W-1:0] margin_y;
  } cfg_t;

  typedef struct packed {
    logic signed [ERRY_W-1:0]             err_yaw;
    logic signed [POSE_W-1:0]             err_x;
    logic signed [POSE_W-1:0]             err_y;
    logic                                 reached;
    logic [NUM_LANES-1:0][ERRY_W-1:0]     mag;
    logic [NUM_LANES-1:0]                 sat;
    logic [NUM_LANES-1:0]                 zero;
  } item_t;

  typedef struct packed {
    item_t                                item;
    logic [NUM_LANES-1:0][REG_W-1:0]      rem;
    logic [NUM_LANES-1:0][SCALE_W-1:0]    quo;
  } stage_t;

endpackage
`default_nettype wire

>>> src/pesc_front.sv
// Front end: accepts a pose word and works out wrapped, saturated errors.
`default_nettype none
module pesc_front import pesc_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire cfg_t                     cfg_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic signed [POSE_W-1:0] current_yaw_i,
  input  wire logic signed [POSE_W-1:0] current_x_i,
  input  wire logic signed [POSE_W-1:0] current_y_i,
  input  wire logic signed [POSE_W-1:0] target_yaw_i,
  input  wire logic signed [POSE_W-1:0] target_x_i,
  input  wire logic signed [POSE_W-1:0] target_y_i,
  output logic                          item_valid_o,
  input  wire logic                     item_ready_i,
  output item_t                         item_o
);

  localparam int unsigned WK = ERRY_W + 1;

  logic signed [WK-1:0] half_w, lim_x_w, lim_y_w, mg_yaw_w, mg_x_w, mg_y_w;
  logic signed [WK-1:0] d_yaw, d_x, d_y, ad_yaw, ad_x, ad_y;
  logic signed [WK-1:0] ey_raw, ey_abs, ex_sat, ey2_sat, ex_abs, ey2_abs;
  logic signed [WK-1:0] m_yaw, m_x, m_y;
  logic                 wrap;
  item_t                item_d;
  item_t                item_q;
  logic                 valid_q;

  assign half_w   = WK'(cfg_i.yaw_half);
  assign lim_x_w  = WK'(cfg_i.limit_x);
  assign lim_y_w  = WK'(cfg_i.limit_y);
  assign mg_yaw_w = WK'(cfg_i.margin_yaw);
  assign mg_x_w   = WK'(cfg_i.margin_x);
  assign mg_y_w   = WK'(cfg_i.margin_y);

  always_comb begin
    d_yaw  = WK'(current_yaw_i) - WK'(target_yaw_i);
    d_x    = WK'(target_x_i) - WK'(current_x_i);
    d_y    = WK'(target_y_i) - WK'(current_y_i);
    ad_yaw = (d_yaw < 0) ? -d_yaw : d_yaw;
    ad_x   = (d_x < 0) ? -d_x : d_x;
    ad_y   = (d_y < 0) ? -d_y : d_y;

    // Go the short way round when the yaws sit on opposite sides of zero and lie at least yaw_half apart
    wrap   = (current_yaw_i[POSE_W-1] != target_yaw_i[POSE_W-1]) && (ad_yaw >= half_w);
    ey_raw = d_yaw;
    if (wrap) begin
      ey_raw = (d_yaw > 0) ? d_yaw - (half_w <<< 1) : d_yaw + (half_w <<< 1);
    end
    ey_abs = (ey_raw < 0) ? -ey_raw : ey_raw;

    ex_sat  = (ad_x > lim_x_w) ? ((d_x < 0) ? -lim_x_w : lim_x_w) : d_x;
    ey2_sat = (ad_y > lim_y_w) ? ((d_y < 0) ? -lim_y_w : lim_y_w) : d_y;
    ex_abs  = (ad_x > lim_x_w) ? lim_x_w : ad_x;
    ey2_abs = (ad_y > lim_y_w) ? lim_y_w : ad_y;

    // Drop errors inside the deadband
    m_yaw = (ey_abs <= mg_yaw_w) ? '0 : ey_abs;
    m_x   = (ex_abs <= mg_x_w) ? '0 : ex_abs;
    m_y   = (ey2_abs <= mg_y_w) ? '0 : ey2_abs;

    item_d.err_yaw = (ey_abs <= mg_yaw_w) ? '0 : ERRY_W'(ey_raw);
    item_d.err_x   = (ex_abs <= mg_x_w) ? '0 : POSE_W'(ex_sat);
    item_d.err_y   = (ey2_abs <= mg_y_w) ? '0 : POSE_W'(ey2_sat);
    item_d.reached = (ad_yaw <= mg_yaw_w) && (ad_x <= mg_x_w) && (ad_y <= mg_y_w);

    item_d.mag[LANE_YAW] = ERRY_W'(m_yaw);
    item_d.mag[LANE_X]   = ERRY_W'(m_x);
    item_d.mag[LANE_Y]   = ERRY_W'(m_y);
    item_d.zero[LANE_YAW] = (m_yaw == 0);
    item_d.zero[LANE_X]   = (m_x == 0);
    item_d.zero[LANE_Y]   = (m_y == 0);
    // Quotient reaches four or more: saturate, covers a zero divisor too
    item_d.sat[LANE_YAW] = (m_yaw != 0) && (m_yaw >= (half_w <<< 2));
    item_d.sat[LANE_X]   = (m_x != 0) && (m_x >= (lim_x_w <<< 2));
    item_d.sat[LANE_Y]   = (m_y != 0) && (m_y >= (lim_y_w <<< 2));
  end

  assign in_ready_o   = !valid_q || item_ready_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_d;
    end
  end

endmodule
`default_nettype wire

>>> src/pesc_fifo.sv
// Short queue of classified words between the front end and the divider.
`default_nettype none
module pesc_fifo import pesc_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_valid_i,
  output logic       push_ready_o,
  input  wire item_t push_item_i,
  output logic       pop_valid_o,
  input  wire logic  pop_ready_i,
  output item_t      pop_item_o
);

  item_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]    cnt_q;
  logic               push, pop;

  assign push_ready_o = (cnt_q != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop) cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule
`default_nettype wire

>>> src/pesc_back.sv
// Back end: pipelined restoring dividers for the three ratios and the result register.
`default_nettype none
module pesc_back import pesc_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire cfg_t          cfg_i,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire item_t         in_item_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic signed [ERRY_W-1:0] error_yaw_o,
  output logic signed [POSE_W-1:0] error_x_o,
  output logic signed [POSE_W-1:0] error_y_o,
  output logic [SCALE_W-1:0] speed_scale_o,
  output logic               reached_o
);

  localparam int unsigned DIV_STEPS = SCALE_W;

  logic [NUM_LANES-1:0][REG_W-1:0] lim;
  stage_t                          stg_q [DIV_STEPS+1];
  stage_t                          stg_d [DIV_STEPS+1];
  logic [DIV_STEPS:0]              vld_q;
  logic                            out_valid_q;
  logic                            adv;
  logic [NUM_LANES-1:0][SCALE_W-1:0] ratio;
  logic [SCALE_W-1:0]              best;

  assign lim[LANE_YAW] = cfg_i.yaw_half;
  assign lim[LANE_X]   = cfg_i.limit_x;
  assign lim[LANE_Y]   = cfg_i.limit_y;

  // One quotient bit per lane; j is the dividend bit brought down
  function automatic stage_t div_step(stage_t s, int unsigned j,
                                      logic [NUM_LANES-1:0][REG_W-1:0] d);
    stage_t         r;
    logic [REG_W:0] t;
    logic           nb;
    r = s;
    for (int l = 0; l < NUM_LANES; l++) begin
      nb = (j >= SCALE_FRAC) ? s.item.mag[l][j - SCALE_FRAC] : 1'b0;
      t  = {s.rem[l], nb};
      if (t >= {1'b0, d[l]}) begin
        r.rem[l] = REG_W'(t - {1'b0, d[l]});
        r.quo[l] = {s.quo[l][SCALE_W-2:0], 1'b1};
      end else begin
        r.rem[l] = REG_W'(t);
        r.quo[l] = {s.quo[l][SCALE_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  always_comb begin
    stg_d[0].item = in_item_i;
    for (int l = 0; l < NUM_LANES; l++) begin
      // Upper dividend bits sit below the divisor once saturation is ruled out
      stg_d[0].rem[l] = REG_W'(in_item_i.mag[l] >> 2);
      stg_d[0].quo[l] = '0;
    end
    for (int k = 0; k < DIV_STEPS; k++) begin
      stg_d[k+1] = div_step(stg_q[k], DIV_STEPS - 1 - k, lim);
    end
  end

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      if (stg_q[DIV_STEPS].item.zero[l]) begin
        ratio[l] = '0;
      end else if (stg_q[DIV_STEPS].item.sat[l]) begin
        ratio[l] = SCALE_MAX;
      end else begin
        ratio[l] = stg_q[DIV_STEPS].quo[l];
      end
    end
    best = ratio[LANE_YAW];
    if (ratio[LANE_X] > best) best = ratio[LANE_X];
    if (ratio[LANE_Y] > best) best = ratio[LANE_Y];
  end

  // Advance the whole pipe unless the result register is held
  assign adv         = !out_valid_q || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[DIV_STEPS-1:0], in_valid_i};
      out_valid_q <= vld_q[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k <= DIV_STEPS; k++) begin
        stg_q[k] <= stg_d[k];
      end
      error_yaw_o   <= stg_q[DIV_STEPS].item.err_yaw;
      error_x_o     <= stg_q[DIV_STEPS].item.err_x;
      error_y_o     <= stg_q[DIV_STEPS].item.err_y;
      reached_o     <= stg_q[DIV_STEPS].item.reached;
      speed_scale_o <= best;
    end
  end

endmodule
`default_nettype wire

>>> src/pose_error_speed_scale.sv
// Top level of the pose error and speed scale block.
// Input channel: in_valid_i / in_ready_o carry one word holding a current and a
// target pose (yaw, x, y). Output channel: out_valid_o / out_ready_i carry the
// wrapped and saturated errors, the speed scale and the reached flag.
// One result leaves for every word taken, in order.
// From acceptance to out_valid_o a word passes the front register, which loads
// at the accepting edge, then one queue slot, the divider entry stage, 18
// divider steps (one quotient bit each, three lanes side by side) and the
// result register. Throughput is one word per cycle unless the receiver
// stalls; the 18-step restoring divider pipeline sets the latency, and the
// combinational error logic in the front sets the rate.
// When the receiver stalls, the divider pipeline and result hold; the front keeps
// taking words until the four-entry queue and its own register are full.
// Configuration: cfg_we_i writes register cfg_idx_i at once; write only when
// the block is empty. Reset empties every stage and loads default registers.
`default_nettype none
`include "pose_error_speed_scale_defines.svh"
module pose_error_speed_scale import pesc_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [REG_W-1:0]         cfg_data_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic signed [POSE_W-1:0] current_yaw_i,
  input  wire logic signed [POSE_W-1:0] current_x_i,
  input  wire logic signed [POSE_W-1:0] current_y_i,
  input  wire logic signed [POSE_W-1:0] target_yaw_i,
  input  wire logic signed [POSE_W-1:0] target_x_i,
  input  wire logic signed [POSE_W-1:0] target_y_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic signed [ERRY_W-1:0]      error_yaw_o,
  output logic signed [POSE_W-1:0]      error_x_o,
  output logic signed [POSE_W-1:0]      error_y_o,
  output logic [SCALE_W-1:0]            speed_scale_o,
  output logic                          reached_o
);

  cfg_t  cfg_q;
  item_t front_item, queue_item;
  logic  front_valid, front_ready, queue_valid, queue_ready;
  logic signed [POSE_W-1:0] lim_x_s, lim_y_s;
  logic  out_err_zero, x_beyond, y_beyond;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.yaw_half   <= RST_YAW_HALF;
      cfg_q.limit_x    <= RST_LIMIT_X;
      cfg_q.limit_y    <= RST_LIMIT_Y;
      cfg_q.margin_yaw <= RST_MARGIN_YAW;
      cfg_q.margin_x   <= RST_MARGIN_X;
      cfg_q.margin_y   <= RST_MARGIN_Y;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_YAW_HALF:   cfg_q.yaw_half   <= cfg_data_i;
        CFG_LIMIT_X:    cfg_q.limit_x    <= cfg_data_i;
        CFG_LIMIT_Y:    cfg_q.limit_y    <= cfg_data_i;
        CFG_MARGIN_YAW: cfg_q.margin_yaw <= cfg_data_i;
        CFG_MARGIN_X:   cfg_q.margin_x   <= cfg_data_i;
        CFG_MARGIN_Y:   cfg_q.margin_y   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pesc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .current_yaw_i (current_yaw_i),
    .current_x_i   (current_x_i),
    .current_y_i   (current_y_i),
    .target_yaw_i  (target_yaw_i),
    .target_x_i    (target_x_i),
    .target_y_i    (target_y_i),
    .item_valid_o  (front_valid),
    .item_ready_i  (front_ready),
    .item_o        (front_item)
  );

  pesc_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_item_i  (front_item),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready),
    .pop_item_o   (queue_item)
  );

  pesc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (queue_valid),
    .in_ready_o    (queue_ready),
    .in_item_i     (queue_item),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .error_yaw_o   (error_yaw_o),
    .error_x_o     (error_x_o),
    .error_y_o     (error_y_o),
    .speed_scale_o (speed_scale_o),
    .reached_o     (reached_o)
  );

  assign lim_x_s = POSE_W'(cfg_q.limit_x);
  assign lim_y_s = POSE_W'(cfg_q.limit_y);

  assign out_err_zero = (error_yaw_o == 0) && (error_x_o == 0) && (error_y_o == 0);
  assign x_beyond     = (error_x_o > lim_x_s) || (error_x_o < -lim_x_s);
  assign y_beyond     = (error_y_o > lim_y_s) || (error_y_o < -lim_y_s);

  `PESC_ASSERT(a_zero_err_zero_scale, (out_valid_o && out_err_zero) |-> (speed_scale_o == 0))
  `PESC_ASSERT_NEVER(a_x_beyond_limit, out_valid_o && x_beyond)
  `PESC_ASSERT_NEVER(a_y_beyond_limit, out_valid_o && y_beyond)

endmodule
`default_nettype wire

>>> dv/tb_top.sv
// Self-checking testbench for the pose error and speed scale block.
`timescale 1ns / 1ps
module tb_top import pesc_pkg::*; ();

  typedef struct {
    logic signed [POSE_W-1:0] cur_yaw, cur_x, cur_y, tgt_yaw, tgt_x, tgt_y;
  } pose_pair_t;

  typedef struct {
    logic signed [ERRY_W-1:0] err_yaw;
    logic signed [POSE_W-1:0] err_x, err_y;
    logic [SCALE_W-1:0]       scale;
    logic                     reached;
  } pose_err_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_YAW_HALF;
  logic [REG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [POSE_W-1:0] current_yaw_i = '0, current_x_i = '0, current_y_i = '0;
  logic signed [POSE_W-1:0] target_yaw_i = '0, target_x_i = '0, target_y_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [ERRY_W-1:0] error_yaw_o;
  logic signed [POSE_W-1:0] error_x_o, error_y_o;
  logic [SCALE_W-1:0] speed_scale_o;
  logic reached_o;

  pose_error_speed_scale i_dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  pose_pair_t pending_poses[$];
  pose_err_t  expected_errs[$];
  logic [REG_W-1:0] regs[6];
  int  send_idle_pct = 17, recv_idle_pct = 87;
  int  hold_off = 0;
  int  fails = 0;

  function automatic longint absv(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint clamp_axis(longint d, longint lim);
    if (absv(d) > lim) return d < 0 ? -lim : lim;
    return d;
  endfunction

  function automatic longint rel_err(longint e, longint lim);
    longint q;
    if (e == 0) return 0;
    if (lim == 0) return 262143;
    q = (e << SCALE_FRAC) / lim;
    return q > 262143 ? 262143 : q;
  endfunction

  function automatic pose_err_t calc_errs(pose_pair_t p);
    pose_err_t r;
    longint half, dyaw, eyaw, ex, ey, s, t, around;
    half = regs[CFG_YAW_HALF];
    dyaw = longint'(p.cur_yaw) - longint'(p.tgt_yaw);
    eyaw = dyaw;
    if ((p.cur_yaw < 0) != (p.tgt_yaw < 0)) begin
      around = 2 * half - absv(dyaw);
      if (around <= absv(dyaw)) eyaw = dyaw > 0 ? dyaw - 2 * half : dyaw + 2 * half;
    end
    ex = clamp_axis(longint'(p.tgt_x) - longint'(p.cur_x), regs[CFG_LIMIT_X]);
    ey = clamp_axis(longint'(p.tgt_y) - longint'(p.cur_y), regs[CFG_LIMIT_Y]);
    if (absv(eyaw) <= regs[CFG_MARGIN_YAW]) eyaw = 0;
    if (absv(ex) <= regs[CFG_MARGIN_X]) ex = 0;
    if (absv(ey) <= regs[CFG_MARGIN_Y]) ey = 0;
    s = rel_err(absv(eyaw), half);
    t = rel_err(absv(ex), regs[CFG_LIMIT_X]);
    if (t > s) s = t;
    t = rel_err(absv(ey), regs[CFG_LIMIT_Y]);
    if (t > s) s = t;
    r.err_yaw = eyaw[ERRY_W-1:0];
    r.err_x = ex[POSE_W-1:0];
    r.err_y = ey[POSE_W-1:0];
    r.scale = s[SCALE_W-1:0];
    r.reached = absv(dyaw) <= regs[CFG_MARGIN_YAW] &&
                absv(longint'(p.cur_x) - longint'(p.tgt_x)) <= regs[CFG_MARGIN_X] &&
                absv(longint'(p.cur_y) - longint'(p.tgt_y)) <= regs[CFG_MARGIN_Y];
    return r;
  endfunction

  // driver: advance to the next word on acceptance, idle at random
  always @(posedge clk_i) begin
    pose_pair_t p;
    if (rst_ni) begin
      if (!in_valid_i || in_ready_o) begin
        if (pending_poses.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          p = pending_poses.pop_front();
          expected_errs.push_back(calc_errs(p));
          in_valid_i <= 1'b1;
          current_yaw_i <= p.cur_yaw; current_x_i <= p.cur_x; current_y_i <= p.cur_y;
          target_yaw_i <= p.tgt_yaw; target_x_i <= p.tgt_x; target_y_i <= p.tgt_y;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver readiness, with a long hold-off when asked
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= $urandom_range(99) >= recv_idle_pct;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    pose_err_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_errs.size() == 0) begin
        $error("result word with nothing expected");
        fails++;
      end else begin
        e = expected_errs.pop_front();
        if (error_yaw_o !== e.err_yaw) begin
          $error("error_yaw exp %0d got %0d", e.err_yaw, error_yaw_o); fails++;
        end
        if (error_x_o !== e.err_x) begin
          $error("error_x exp %0d got %0d", e.err_x, error_x_o); fails++;
        end
        if (error_y_o !== e.err_y) begin
          $error("error_y exp %0d got %0d", e.err_y, error_y_o); fails++;
        end
        if (speed_scale_o !== e.scale) begin
          $error("speed_scale exp %0d got %0d", e.scale, speed_scale_o); fails++;
        end
        if (reached_o !== e.reached) begin
          $error("reached exp %0d got %0d", e.reached, reached_o); fails++;
        end
      end
    end
  end

  function automatic logic signed [POSE_W-1:0] rand_pose();
    case ($urandom_range(3))
      0: return POSE_W'($urandom);
      1: return POSE_W'($signed(POSE_W'($urandom_range(4096))) - 2048);
      2: return $urandom_range(1) ? {1'b0, {(POSE_W-1){1'b1}}} : {1'b1, {(POSE_W-1){1'b0}}};
      default: return POSE_W'($signed(POSE_W'($urandom_range(1600))) - 800);
    endcase
  endfunction

  task automatic add_pose(longint cy, longint cx, longint cyy,
                          longint ty, longint tx, longint tyy);
    pose_pair_t p;
    p.cur_yaw = POSE_W'(cy); p.cur_x = POSE_W'(cx); p.cur_y = POSE_W'(cyy);
    p.tgt_yaw = POSE_W'(ty); p.tgt_x = POSE_W'(tx); p.tgt_y = POSE_W'(tyy);
    pending_poses.push_back(p);
  endtask

  task automatic add_random(int n);
    pose_pair_t p;
    repeat (n) begin
      p.cur_yaw = rand_pose(); p.tgt_yaw = rand_pose();
      p.cur_x = rand_pose(); p.tgt_x = rand_pose();
      p.cur_y = rand_pose(); p.tgt_y = rand_pose();
      // near-target samples to hit the deadband and reached flag
      if ($urandom_range(4) == 0) begin
        p.tgt_x = POSE_W'(p.cur_x + $signed(POSE_W'($urandom_range(20))) - 10);
        p.tgt_y = POSE_W'(p.cur_y + $signed(POSE_W'($urandom_range(20))) - 10);
        p.tgt_yaw = POSE_W'(p.cur_yaw + $signed(POSE_W'($urandom_range(6))) - 3);
      end
      pending_poses.push_back(p);
    end
  endtask

  task automatic drain();
    while (pending_poses.size() > 0 || expected_errs.size() > 0 || in_valid_i)
      @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [REG_W-1:0] v);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= v;
    regs[idx] = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_all(logic [REG_W-1:0] h, lx, ly, my, mx, myy);
    write_reg(CFG_YAW_HALF, h); write_reg(CFG_LIMIT_X, lx);
    write_reg(CFG_LIMIT_Y, ly); write_reg(CFG_MARGIN_YAW, my);
    write_reg(CFG_MARGIN_X, mx); write_reg(CFG_MARGIN_Y, myy);
  endtask

  localparam longint PMAX = 524287, PMIN = -524288;

  initial begin
    regs[CFG_YAW_HALF] = RST_YAW_HALF; regs[CFG_LIMIT_X] = RST_LIMIT_X;
    regs[CFG_LIMIT_Y] = RST_LIMIT_Y; regs[CFG_MARGIN_YAW] = RST_MARGIN_YAW;
    regs[CFG_MARGIN_X] = RST_MARGIN_X; regs[CFG_MARGIN_Y] = RST_MARGIN_Y;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: extremes, zero yaw, wrap both ways, deadband, saturation
    add_pose(0, 0, 0, 0, 0, 0);
    add_pose(PMAX, PMAX, PMAX, PMIN, PMIN, PMIN);
    add_pose(PMIN, PMIN, PMIN, PMAX, PMAX, PMAX);
    add_pose(700, 100, -100, -700, 6000, -6000);
    add_pose(-700, 0, 0, 700, 513, -513);
    add_pose(0, 0, 0, -5, 512, -512);
    add_pose(-1, 0, 0, 0, 5119, -5121);
    add_pose(100, 0, 0, -100, 0, 0);
    add_pose(804, 0, 0, -804, 0, 0);
    add_pose(-804, 0, 0, 804, 0, 0);
    add_pose(3000, 0, 0, -3000, 0, 0);
    add_pose(13, 1, 1, 0, 0, 0);
    add_pose(14, 0, 0, 0, 0, 0);
    add_pose(-1, -1, -1, -1, -1, -1);
    drain();
    add_random(300);
    drain();
    write_all(1, 1, 1, 0, 0, 0);
    add_pose(1, 1, 0, -1, 0, 1);
    add_pose(PMAX, PMAX, PMIN, PMIN, PMIN, PMAX);
    add_random(200);
    drain();
    send_idle_pct = 87; recv_idle_pct = 17;
    write_all(524287, 524287, 524287, 524287, 524287, 524287);
    add_random(200);
    drain();
    write_all(200000, 70000, 3, 100, 2000, 1);
    add_random(250);
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    write_all(1608, 256, 100000, 0, 10, 300);
    hold_off <= 60;
    add_random(330);
    drain();
    if (fails == 0 && expected_errs.size() == 0)
      $display("pose_error_speed_scale: match");
    else
      $display("pose_error_speed_scale: mismatch");
    $finish;
  end

  initial begin
    #20ms;
    $display("pose_error_speed_scale: mismatch");
    $finish;
  end
endmodule

>>> pose_error_speed_scale.f
+incdir+src
src/pesc_pkg.sv
src/pesc_front.sv
src/pesc_fifo.sv
src/pesc_back.sv
src/pose_error_speed_scale.sv
dv/tb_top.sv
